@@ rtl/sd_spi_block_receiver_core_macros.svh @@
// assertion macros for the sd spi block receiver checker
// no dependencies; included by the checker file only
`ifndef SD_SPI_BLOCK_RECEIVER_CORE_MACROS_SVH
`define SD_SPI_BLOCK_RECEIVER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SDBR_ASSERT_SAME(lbl, clock, resetn, ante, cons, msg) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SDBR_ASSERT_NEXT(lbl, clock, resetn, ante, cons, msg) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sdbr_pkg.sv @@
// shared types, codes and helpers for the sd spi block receiver
// no dependencies; imported by every module of the block
package sdbr_pkg;

    localparam int MAX_BLOCK_BYTES = 2048;
    localparam int LEN_W           = $clog2(MAX_BLOCK_BYTES + 1);

    localparam logic [7:0]  FILL_BYTE = 8'hFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    localparam logic [1:0] CMD_ARM  = 2'd0;
    localparam logic [1:0] CMD_BYTE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_BAD_TOK = 2'd2;
    localparam logic [1:0] ST_CRC_ERR = 2'd3;

    localparam logic [1:0] REG_START_TOKEN = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_MS  = 2'd1;
    localparam logic [1:0] REG_BLOCK_BYTES = 2'd2;
    localparam logic [1:0] REG_CRC_CHECK   = 2'd3;

    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_WAIT = 5'b00010,
        PH_DATA = 5'b00100,
        PH_CRCH = 5'b01000,
        PH_CRCL = 5'b10000
    } phase_t;

    // zero acts as one, anything above the maximum is clamped
    function automatic logic [LEN_W-1:0] block_len(input logic [11:0] bb);
        logic [LEN_W-1:0] n;
        begin
            if (bb == 12'd0)
            begin
                n = LEN_W'(1);
            end
            else if (int'(bb) > MAX_BLOCK_BYTES)
            begin
                n = LEN_W'(MAX_BLOCK_BYTES);
            end
            else
            begin
                n = LEN_W'(bb);
            end
            return n;
        end
    endfunction

endpackage

@@ rtl/sdbr_crc16.sv @@
// crc-16 ccitt byte update, msb first, no reflection
// depends on sdbr_pkg for the polynomial
module sdbr_crc16 (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);
    import sdbr_pkg::*;

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

@@ rtl/sd_spi_block_receiver_core.sv @@
// sd card spi data block receiver: token hunt, data pass-through, crc-16 check
// depends on sdbr_pkg and sdbr_crc16
//
// usage:
//   s_* channel takes one item per handshake: tuser holds the command
//   (arm, received byte, millisecond tick), tdata the received byte.
//   m_* channel returns exactly one result item per input item: the data
//   byte and status in tdata, the data-valid and done flags in tuser.
//   cfg_* channel writes start token, timeout, block length and crc enable;
//   cfg_ready is always high and a write takes effect on the next cycle.
// path: an accepted item is held in the input register, and its result is then
//   registered in the result register, from which it is presented.
// throughput: one item per cycle unless m_tready stalls a held result; the receive
//   state (phase, byte count, crc, tick count) is updated directly from the input
//   register through the byte-wide crc unit, so consecutive items never wait on each other.
// reset: configuration, control state and valid flags reset at once (data registers
//   are not reset); the receiver is idle, both channels are empty; no clearing pass.
// stall: while m_tready is low the result is held, the input register
//   keeps one more item and s_tready then drops until the result is taken.
module sd_spi_block_receiver_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // slave side
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sdbr_pkg::IN_TDATA_W-1:0]      s_tdata,   // [7:0] rx_byte
    input  logic [sdbr_pkg::IN_TUSER_W-1:0]      s_tuser,   // [1:0] cmd
    // master side
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sdbr_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [7:0] data_byte, [9:8] status
    output logic [sdbr_pkg::OUT_TUSER_W-1:0]     m_tuser,   // [0] data_valid, [1] done_res
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [1:0]                           cfg_index,
    input  logic [sdbr_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import sdbr_pkg::*;

    // configuration
    logic [7:0]  start_token_reg;
    logic [15:0] timeout_ms_reg;
    logic [11:0] block_bytes_reg;
    logic        crc_check_reg;

    // input stage
    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic [7:0]  in_byte_reg;

    // receive state
    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] bytes_seen_reg, bytes_seen_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_high_reg, crc_high_next;
    logic [15:0]      elapsed_reg, elapsed_next;

    // result stage
    logic        out_valid_reg;
    logic [7:0]  data_byte_reg, data_byte_next;
    logic        data_valid_reg, data_valid_next;
    logic        done_reg, done_next;
    logic [1:0]  status_reg, status_next;

    logic             advance;
    logic             fire;
    logic [15:0]      crc_upd;
    logic [LEN_W:0]   count_inc;
    logic [LEN_W-1:0] len;

    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 10){1'b0}}, status_reg, data_byte_reg};
    assign m_tuser  = {done_reg, data_valid_reg};

    sdbr_crc16 u_crc (
        .crc_in  (crc_reg),
        .data_in (in_byte_reg),
        .crc_out (crc_upd)
    );

    assign len       = block_len(block_bytes_reg);
    assign count_inc = {1'b0, bytes_seen_reg} + {{LEN_W{1'b0}}, 1'b1};

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_seen_next = bytes_seen_reg;
        crc_next        = crc_reg;
        crc_high_next   = crc_high_reg;
        elapsed_next    = elapsed_reg;
        data_byte_next  = 8'h00;
        data_valid_next = 1'b0;
        done_next       = 1'b0;
        status_next     = ST_OK;

        unique case (in_cmd_reg)
            CMD_ARM:
            begin
                phase_next      = PH_WAIT;
                bytes_seen_next = '0;
                crc_next        = 16'h0000;
                crc_high_next   = 8'h00;
                elapsed_next    = 16'h0000;
            end
            CMD_TICK:
            begin
                if (phase_reg == PH_WAIT)
                begin
                    if (elapsed_reg >= timeout_ms_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_TIMEOUT;
                        phase_next  = PH_IDLE;
                    end
                    else
                    begin
                        elapsed_next = elapsed_reg + 16'd1;
                    end
                end
            end
            CMD_BYTE:
            begin
                unique case (phase_reg)
                    PH_WAIT:
                    begin
                        // fill bytes are skipped while hunting for the token
                        if (in_byte_reg != FILL_BYTE)
                        begin
                            if (in_byte_reg == start_token_reg)
                            begin
                                phase_next      = PH_DATA;
                                bytes_seen_next = '0;
                                crc_next        = 16'h0000;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BAD_TOK;
                                phase_next  = PH_IDLE;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        data_byte_next  = in_byte_reg;
                        data_valid_next = 1'b1;
                        crc_next        = crc_upd;
                        bytes_seen_next = count_inc[LEN_W-1:0];
                        if (count_inc >= {1'b0, len})
                        begin
                            phase_next = PH_CRCH;
                        end
                    end
                    PH_CRCH:
                    begin
                        crc_high_next = in_byte_reg;
                        phase_next    = PH_CRCL;
                    end
                    PH_CRCL:
                    begin
                        done_next  = 1'b1;
                        phase_next = PH_IDLE;
                        if (crc_check_reg && ({crc_high_reg, in_byte_reg} != crc_reg))
                        begin
                            status_next = ST_CRC_ERR;
                        end
                    end
                    default:
                    begin
                        // idle: bytes are ignored
                    end
                endcase
            end
            default:
            begin
                // unused command code: ignored
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_token_reg <= 8'hFE;
            timeout_ms_reg  <= 16'd300;
            block_bytes_reg <= 12'd512;
            crc_check_reg   <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START_TOKEN: start_token_reg <= cfg_data[7:0];
                REG_TIMEOUT_MS:  timeout_ms_reg  <= cfg_data[15:0];
                REG_BLOCK_BYTES: block_bytes_reg <= cfg_data[11:0];
                REG_CRC_CHECK:   crc_check_reg   <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= s_tuser[1:0];
            in_byte_reg <= s_tdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bytes_seen_reg <= '0;
            crc_reg        <= 16'h0000;
            crc_high_reg   <= 8'h00;
            elapsed_reg    <= 16'h0000;
            out_valid_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            bytes_seen_reg <= bytes_seen_next;
            crc_reg        <= crc_next;
            crc_high_reg   <= crc_high_next;
            elapsed_reg    <= elapsed_next;
            out_valid_reg  <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_byte_reg  <= data_byte_next;
            data_valid_reg <= data_valid_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
        end
    end

endmodule

@@ rtl/sdbr_checker.sv @@
// port-level checks for the sd spi block receiver, bound to the top level
// depends on sdbr_pkg and sd_spi_block_receiver_core_macros.svh
`include "sd_spi_block_receiver_core_macros.svh"

module sdbr_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [sdbr_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic [sdbr_pkg::OUT_TUSER_W-1:0]     m_tuser
);
    import sdbr_pkg::*;

    // a data byte and a block end never share one item
    `SDBR_ASSERT_SAME(a_data_xor_done, clk, rst_n, m_tvalid, !(m_tuser[0] && m_tuser[1]), "data and done together")

    // status is only nonzero on the done item
    `SDBR_ASSERT_SAME(a_status_needs_done, clk, rst_n, m_tvalid && !m_tuser[1], m_tdata[9:8] == ST_OK, "status without done")

    // data byte is zero unless it carries block data
    `SDBR_ASSERT_SAME(a_idle_byte_zero, clk, rst_n, m_tvalid && !m_tuser[0], m_tdata[7:0] == 8'h00, "stray data byte")

    // a stalled result holds
    `SDBR_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed under stall")

endmodule

bind sd_spi_block_receiver_core sdbr_checker u_sdbr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

@@ test/sd_spi_block_receiver_checker.sv @@
`timescale 1ns / 100ps
// checker for the sd spi block receiver: watches the input, result and config channels,
// predicts every result item and compares it field by field with what the block returns
// depends on sdbr_pkg
module sd_spi_block_receiver_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [sdbr_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  logic [sdbr_pkg::IN_TUSER_W-1:0]  s_tuser,   // [1:0] cmd
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [sdbr_pkg::OUT_TDATA_W-1:0] m_tdata,   // [7:0] data_byte, [9:8] status
    input  logic [sdbr_pkg::OUT_TUSER_W-1:0] m_tuser,   // [0] data_valid, [1] done_res
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [sdbr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               fail_count,
    output int                               pending_count,
    output int                               data_count,
    output int                               ok_count,
    output int                               timeout_count,
    output int                               bad_token_count,
    output int                               crc_err_count
);
    import sdbr_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       done_res;
        logic [1:0] status;
    } rx_result_t;

    // register copies
    logic [7:0]  token_q;
    logic [15:0] timeout_q;
    logic [11:0] block_bytes_q;
    logic        crc_check_q;

    // receive state
    phase_t      rx_phase;
    logic [11:0] byte_count;
    logic [15:0] crc_acc;
    logic [7:0]  crc_hi;
    logic [15:0] tick_count;

    rx_result_t  results_due[$];
    rx_result_t  want;
    rx_result_t  got;

    function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        begin
            c = crc ^ {b, 8'h00};
            for (int i = 0; i < 8; i++)
            begin
                c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
            return c;
        end
    endfunction

    function automatic logic [11:0] data_len(input logic [11:0] n);
        begin
            if (n == 12'd0)
            begin
                return 12'd1;
            end
            if (n > 12'(MAX_BLOCK_BYTES))
            begin
                return 12'(MAX_BLOCK_BYTES);
            end
            return n;
        end
    endfunction

    task automatic receive_step(input logic [1:0] cmd, input logic [7:0] b, output rx_result_t r);
        begin
            r = '0;
            case (cmd)
                CMD_ARM:
                begin
                    rx_phase   = PH_WAIT;
                    byte_count = '0;
                    crc_acc    = '0;
                    crc_hi     = '0;
                    tick_count = '0;
                end
                CMD_TICK:
                begin
                    // ticks only count while hunting for the token
                    if (rx_phase == PH_WAIT)
                    begin
                        if (tick_count >= timeout_q)
                        begin
                            r.done_res = 1'b1;
                            r.status   = ST_TIMEOUT;
                            rx_phase   = PH_IDLE;
                        end
                        else
                        begin
                            tick_count = tick_count + 16'd1;
                        end
                    end
                end
                CMD_BYTE:
                begin
                    case (rx_phase)
                        PH_WAIT:
                        begin
                            if (b != FILL_BYTE)
                            begin
                                if (b == token_q)
                                begin
                                    rx_phase   = PH_DATA;
                                    byte_count = '0;
                                    crc_acc    = '0;
                                end
                                else
                                begin
                                    r.done_res = 1'b1;
                                    r.status   = ST_BAD_TOK;
                                    rx_phase   = PH_IDLE;
                                end
                            end
                        end
                        PH_DATA:
                        begin
                            r.data_byte  = b;
                            r.data_valid = 1'b1;
                            crc_acc      = crc16_ccitt_byte(crc_acc, b);
                            byte_count   = byte_count + 12'd1;
                            if (byte_count >= data_len(block_bytes_q))
                            begin
                                rx_phase = PH_CRCH;
                            end
                        end
                        PH_CRCH:
                        begin
                            crc_hi   = b;
                            rx_phase = PH_CRCL;
                        end
                        PH_CRCL:
                        begin
                            r.done_res = 1'b1;
                            r.status   = (crc_check_q && ({crc_hi, b} != crc_acc)) ? ST_CRC_ERR
                                                                                   : ST_OK;
                            rx_phase   = PH_IDLE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    endtask

    task automatic report_bad(input string what, input rx_result_t w, input rx_result_t g);
        begin
            fail_count++;
            if (fail_count <= 10)
            begin
                $display("%0t: %s: expected data %02h valid %0b done %0b status %0d,",
                         $time, what, w.data_byte, w.data_valid, w.done_res, w.status);
                $display("    got data %02h valid %0b done %0b status %0d",
                         g.data_byte, g.data_valid, g.done_res, g.status);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_q         = 8'hFE;
            timeout_q       = 16'd300;
            block_bytes_q   = 12'd512;
            crc_check_q     = 1'b1;
            rx_phase        = PH_IDLE;
            byte_count      = '0;
            crc_acc         = '0;
            crc_hi          = '0;
            tick_count      = '0;
            results_due.delete();
            fail_count      = 0;
            pending_count   = 0;
            data_count      = 0;
            ok_count        = 0;
            timeout_count   = 0;
            bad_token_count = 0;
            crc_err_count   = 0;
        end
        else
        begin
            // compare before predicting so a result never meets its own item
            if (m_tvalid && m_tready)
            begin
                got.data_byte  = m_tdata[7:0];
                got.status     = m_tdata[9:8];
                got.data_valid = m_tuser[0];
                got.done_res   = m_tuser[1];
                if (results_due.size() == 0)
                begin
                    report_bad("result item with nothing expected", '0, got);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (want.data_byte != got.data_byte || want.data_valid != got.data_valid ||
                        want.done_res != got.done_res || want.status != got.status)
                    begin
                        report_bad("result mismatch", want, got);
                    end
                    if (want.data_valid)
                    begin
                        data_count++;
                    end
                    if (want.done_res)
                    begin
                        case (want.status)
                            ST_OK:      ok_count++;
                            ST_TIMEOUT: timeout_count++;
                            ST_BAD_TOK: bad_token_count++;
                            default:    crc_err_count++;
                        endcase
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                receive_step(s_tuser, s_tdata, want);
                results_due.push_back(want);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_START_TOKEN: token_q       = cfg_data[7:0];
                    REG_TIMEOUT_MS:  timeout_q     = cfg_data[15:0];
                    REG_BLOCK_BYTES: block_bytes_q = cfg_data[11:0];
                    REG_CRC_CHECK:   crc_check_q   = cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            pending_count = results_due.size();
        end
    end

endmodule

@@ test/tb_sd_spi_block_receiver_core.sv @@
`timescale 1ns / 100ps
// top of the sd spi block receiver testbench: clock, reset, config phases and item stimulus
// depends on sdbr_pkg, sd_spi_block_receiver_core and sd_spi_block_receiver_checker
module tb_sd_spi_block_receiver_core;
    import sdbr_pkg::*;

    localparam int         CYCLE_LIMIT   = 500000;
    localparam int         RANDOM_PHASES = 5;
    localparam logic [1:0] CMD_RESERVED  = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [7:0] rx_byte
    logic [IN_TUSER_W-1:0]  s_tuser   = '0;   // [1:0] cmd
    logic                   m_tvalid;
    logic                   m_tready  = 1'b1;
    logic [OUT_TDATA_W-1:0] m_tdata;          // [7:0] data_byte, [9:8] status
    logic [OUT_TUSER_W-1:0] m_tuser;          // [0] data_valid, [1] done_res
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [1:0]             cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int fail_count;
    int pending_count;
    int data_count;
    int ok_count;
    int timeout_count;
    int bad_token_count;
    int crc_err_count;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int phase_count   = 0;
    int cycle_count   = 0;

    // stimulus view of the current register settings
    logic [7:0] cur_token;
    int         cur_timeout;
    int         cur_len;

    sd_spi_block_receiver_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sd_spi_block_receiver_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .data_count      (data_count),
        .ok_count        (ok_count),
        .timeout_count   (timeout_count),
        .bad_token_count (bad_token_count),
        .crc_err_count   (crc_err_count)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        m_tready = ($urandom_range(0, 99) < recv_idle_pct) ? 1'b0 : 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count, pending_count);
            $display("FAILURE");
            $finish;
        end
    end

    // crc of the generated data, so that well-formed blocks carry a matching trailer
    function automatic logic [15:0] crc_after(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        begin
            c = crc ^ {b, 8'h00};
            for (int i = 0; i < 8; i++)
            begin
                c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
            return c;
        end
    endfunction

    // called right after a falling edge, returns right after a falling edge
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] rx);
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                s_tvalid = 1'b0;
                @(negedge clk);
            end
            s_tvalid = 1'b1;
            s_tuser  = cmd;
            s_tdata  = rx;
            @(posedge clk);
            while (!s_tready)
            begin
                @(posedge clk);
            end
            items_sent++;
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        begin
            cfg_valid = 1'b1;
            cfg_index = idx;
            cfg_data  = val;
            @(posedge clk);
            while (!cfg_ready)
            begin
                @(posedge clk);
            end
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    task automatic set_config(input logic [7:0] tok, input logic [15:0] tmo,
                              input logic [11:0] len, input logic chk);
        begin
            write_reg(REG_START_TOKEN, {8'h00, tok});
            write_reg(REG_TIMEOUT_MS, tmo);
            write_reg(REG_BLOCK_BYTES, {4'h0, len});
            write_reg(REG_CRC_CHECK, {15'h0000, chk});
            cur_token   = tok;
            cur_timeout = tmo;
            if (len == 12'd0)
            begin
                cur_len = 1;
            end
            else if (len > 12'(MAX_BLOCK_BYTES))
            begin
                cur_len = MAX_BLOCK_BYTES;
            end
            else
            begin
                cur_len = len;
            end
        end
    endtask

    task automatic set_mode(input int mode);
        begin
            case (mode)
                1:
                begin
                    send_idle_pct = 79;
                    recv_idle_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 79;
                end
                3:
                begin
                    send_idle_pct = 18;
                    recv_idle_pct = 18;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
        end
    endtask

    // wait until every result is back, then let the pipeline settle
    task automatic drain();
        begin
            s_tvalid = 1'b0;
            while (pending_count != 0)
            begin
                @(negedge clk);
            end
            repeat (4) @(negedge clk);
            phase_count++;
        end
    endtask

    task automatic send_block(input int corrupt_pct);
        int          n;
        int          ticks_used;
        logic [15:0] crc;
        logic [7:0]  d;
        begin
            send_item(CMD_ARM, 8'($urandom));
            ticks_used = 0;
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
            begin
                // stay below the timeout while hunting
                if ($urandom_range(0, 1) == 1 && ticks_used < cur_timeout)
                begin
                    send_item(CMD_TICK, 8'($urandom));
                    ticks_used++;
                end
                else
                begin
                    send_item(CMD_BYTE, FILL_BYTE);
                end
            end
            send_item(CMD_BYTE, cur_token);
            crc = 16'h0000;
            for (int i = 0; i < cur_len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(CMD_TICK, 8'($urandom));
                end
                d = 8'($urandom);
                send_item(CMD_BYTE, d);
                crc = crc_after(crc, d);
            end
            if ($urandom_range(0, 99) < corrupt_pct)
            begin
                crc = crc ^ 16'($urandom_range(1, 65535));
            end
            send_item(CMD_BYTE, crc[15:8]);
            send_item(CMD_BYTE, crc[7:0]);
        end
    endtask

    task automatic send_timeout_run();
        int n;
        begin
            send_item(CMD_ARM, 8'($urandom));
            n = (cur_timeout <= 40) ? cur_timeout + 1 : $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    send_item(CMD_BYTE, FILL_BYTE);
                end
                send_item(CMD_TICK, 8'($urandom));
            end
        end
    endtask

    // also used to bring the receiver back to idle at the end of a phase
    task automatic send_bad_token();
        logic [7:0] b;
        begin
            send_item(CMD_ARM, 8'($urandom));
            if ($urandom_range(0, 1) == 1)
            begin
                send_item(CMD_BYTE, FILL_BYTE);
            end
            b = 8'($urandom_range(0, 254));
            if (b == cur_token)
            begin
                b = (b == 8'h00) ? 8'h01 : b - 8'h01;
            end
            send_item(CMD_BYTE, b);
        end
    endtask

    task automatic send_abandoned();
        int k;
        begin
            send_item(CMD_ARM, 8'($urandom));
            send_item(CMD_BYTE, cur_token);
            k = $urandom_range(0, cur_len - 1);
            for (int i = 0; i < k; i++)
            begin
                send_item(CMD_BYTE, 8'($urandom));
            end
        end
    endtask

    task automatic run_random(input int budget);
        int first;
        int pick;
        int n;
        begin
            first = items_sent;
            while (items_sent - first < budget)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    send_block(25);
                end
                else if (pick < 67)
                begin
                    send_timeout_run();
                end
                else if (pick < 77)
                begin
                    send_bad_token();
                end
                else if (pick < 87)
                begin
                    send_abandoned();
                end
                else
                begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                    begin
                        send_item(2'($urandom_range(0, 3)), 8'($urandom));
                    end
                end
            end
            send_bad_token();
            drain();
        end
    endtask

    task automatic run_directed();
        logic [15:0] c;
        begin
            // while idle: bytes, ticks and the unused command do nothing
            send_item(CMD_BYTE, 8'h5A);
            send_item(CMD_TICK, 8'h00);
            send_item(CMD_RESERVED, 8'hFF);
            // fill byte skipped, then timeout on the second tick
            send_item(CMD_ARM, 8'h00);
            send_item(CMD_BYTE, FILL_BYTE);
            send_item(CMD_TICK, 8'h00);
            send_item(CMD_TICK, 8'h00);
            // wrong token
            send_item(CMD_ARM, 8'h00);
            send_item(CMD_BYTE, 8'h00);
            // good block with a tick inside the data, which is ignored
            send_item(CMD_ARM, 8'h00);
            send_item(CMD_BYTE, 8'hFE);
            send_item(CMD_BYTE, 8'h00);
            send_item(CMD_TICK, 8'h00);
            send_item(CMD_BYTE, 8'hFF);
            c = crc_after(crc_after(16'h0000, 8'h00), 8'hFF);
            send_item(CMD_BYTE, c[15:8]);
            send_item(CMD_BYTE, c[7:0]);
            // block with a broken crc
            send_item(CMD_ARM, 8'hFF);
            send_item(CMD_BYTE, 8'hFE);
            send_item(CMD_BYTE, 8'hFF);
            send_item(CMD_BYTE, 8'h00);
            c = crc_after(crc_after(16'h0000, 8'hFF), 8'h00);
            send_item(CMD_BYTE, c[15:8] ^ 8'h80);
            send_item(CMD_BYTE, c[7:0]);
            // re-arm in the middle of the data drops the block silently
            send_item(CMD_ARM, 8'h00);
            send_item(CMD_BYTE, 8'hFE);
            send_item(CMD_BYTE, 8'h80);
            send_item(CMD_ARM, 8'h00);
            send_item(CMD_BYTE, 8'h01);
        end
    endtask

    initial
    begin
        int p;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        set_mode(0);
        set_config(8'hFE, 16'd1, 12'd2, 1'b1);
        run_directed();
        drain();

        // zero token, zero timeout, zero length (acts as one)
        set_mode(1);
        set_config(8'h00, 16'd0, 12'd0, 1'b1);
        run_random(200);

        // token equal to fill can never open a block, longest timeout, crc ignored
        set_mode(2);
        set_config(8'hFF, 16'hFFFF, 12'd1, 1'b0);
        run_random(150);

        // one status-sized block with a good trailer
        set_mode(3);
        set_config(8'hFE, 16'd300, 12'd64, 1'b1);
        send_block(0);
        drain();

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            set_mode(p % 4);
            set_config(($urandom_range(0, 1) == 1) ? 8'hFE : 8'($urandom),
                       16'($urandom_range(1, 6)), 12'($urandom_range(1, 16)),
                       1'($urandom_range(0, 1)));
            run_random(180);
        end

        $display("%0d items over %0d phases, %0d data bytes passed through",
                 items_sent, phase_count, data_count);
        $display("blocks ended: %0d ok, %0d timeout, %0d bad token, %0d crc mismatch",
                 ok_count, timeout_count, bad_token_count, crc_err_count);
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
